// ===== design/tiis_pkg.sv =====
// Shared types, constants and CORDIC angle tables for the THINC intercept solver.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package tiis_pkg;

   // Fixed-point formats
   localparam int FRAC = 30;                 // Q30 fraction bits of the tanh domain
   localparam int NEWTON_STEPS_DEF = 8;      // default Newton step budget
   localparam int IW   = 20;                 // intercept width, Q3.16
   localparam int XW   = 44;                 // CORDIC x/y width
   localparam int ZW   = 36;                 // CORDIC angle width
   localparam int DVW  = 64;                 // divider dividend and quotient width
   localparam int DSW  = 48;                 // divider divisor width
   localparam int QBW  = 7;                  // quotient bit count width
   localparam int MAW  = 36;                 // multiplier operand a width
   localparam int MBW  = 32;                 // multiplier operand b width
   localparam int PW   = MAW + MBW;          // product width
   localparam int TW   = 31;                 // tanh magnitude width, 0..ONE
   localparam int AGW  = 42;                 // tanh argument width
   localparam int CSRW = 17;                 // configuration data width

   localparam logic [TW-1:0] ONE_Q30   = TW'(1) << FRAC;
   localparam logic [TW-1:0] GAUSS_LO  = 31'd226908346;
   localparam logic [TW-1:0] GAUSS_HI  = ONE_Q30 - GAUSS_LO;
   localparam logic signed [AGW-1:0] ARG_LIMIT = 42'sd21474836480;   // 20.0 in Q30
   localparam logic [16:0] BETA_RESET  = 17'd24576;                  // 6.0
   localparam logic signed [IW-1:0] D_MIN = -20'sd524288;
   localparam logic signed [IW-1:0] D_MAX = 20'sd524287;

   // Quotient lengths used by the divider
   localparam logic [QBW-1:0] QBITS_FULL = 7'd64;
   localparam logic [QBW-1:0] QBITS_TANH = 7'd34;

   // Configuration register indexes
   localparam logic CSR_BETA = 1'b0;
   localparam logic CSR_MODE = 1'b1;

   // Result status codes
   localparam logic [1:0] STAT_MIDPOINT  = 2'd0;
   localparam logic [1:0] STAT_CONVERGED = 2'd1;
   localparam logic [1:0] STAT_FLAT      = 2'd2;
   localparam logic [1:0] STAT_LIMIT     = 2'd3;

   typedef logic [TW-1:0] hyp_entry_type;
   typedef hyp_entry_type hyp_tab_type [1:FRAC];

   // atanh(2^-i) in Q30, summed from its odd power series and rounded
   function automatic hyp_tab_type build_hyp_tab();
      hyp_tab_type tab;
      logic [63:0] s;
      int k;
      for (int i = 1; i <= FRAC; i++) begin
         s = '0;
         for (k = 1; i * k <= 60; k += 2) begin
            s += (64'd1 << (60 - i * k)) / 64'(k);
         end
         tab[i] = hyp_entry_type'((s + (64'd1 << 29)) >> 30);
      end
      return tab;
   endfunction

   // ln(2)/2 = atanh(1/3) in Q30
   function automatic hyp_entry_type build_half_ln2();
      logic [63:0] s;
      logic [63:0] p;
      int k;
      s = '0;
      p = (64'd1 << 60) / 64'd3;
      k = 1;
      while (p != 0) begin
         s += p / 64'(k);
         p = p / 64'd9;
         k += 2;
      end
      return hyp_entry_type'((s + (64'd1 << 29)) >> 30);
   endfunction

   localparam hyp_tab_type   HYP_TAB  = build_hyp_tab();
   localparam hyp_entry_type HALF_LN2 = build_half_ln2();

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_ctl_type;

   typedef struct packed {
      logic             start;
      logic [QBW-1:0]   qbits;
   } div_ctl_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ANORM_HI, ST_ANORM_LO, ST_ASCALE, ST_ACORD, ST_AEMUL, ST_ASUM,
      ST_MDIV, ST_NSTEP, ST_NDOT0, ST_NDOT1, ST_NDOT2, ST_NDOT3, ST_NARGM, ST_NARG,
      ST_NHALVE, ST_NTCORD, ST_NTDIV, ST_NDBL, ST_NDBL_DIV, ST_NDBL_WAIT, ST_NACC,
      ST_NNEXT, ST_NDEN, ST_NDEN_DIV, ST_NDDIV, ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== design/thinc_interface_intercept_solver.sv =====
// Top level of the THINC intercept solver: sequencer, shared multiplier, registers.
// Depends on tiis_pkg, tiis_cordic and tiis_divider.
//
// Usage:
//   req_* carries one item: alpha, normal_x, normal_y, normal_z. rsp_* returns one
//   item per request: intercept (Q3.16, saturated) and solve_status.
//   csr_* writes beta (index 0) and quadrature_mode (index 1); write only while idle.
// Operation:
//   One item at a time; req_tready is high only while the sequencer is idle.
//   Midpoint mode runs up to 16 normalizing steps, the scaling steps, a CORDIC
//   vectoring pass and a divide.
//   Gauss mode adds per Newton step 8 nodes (three dot-product multiplies and
//   one by beta, up to 5 halvings, a CORDIC rotation, one divide plus one divide
//   and one squaring per halving; a saturated node skips the CORDIC and divides)
//   and a final divide.
//   The divider yields one quotient bit per cycle and the CORDIC is serial.
// Reset: synchronous; beta returns to 6.0, mode to midpoint, the sequencer to idle.
// Stall: a finished item waits in the rsp register; a new request is accepted
//   meanwhile, and its result waits in the last state until the register frees.
`default_nettype none

module thinc_interface_intercept_solver import tiis_pkg::*; #(
   parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [63:0]     req_tdata,   // alpha[15:0], normal_x[31:16], normal_y[47:32],
                                        // normal_z[63:48]
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [23:0]     rsp_tdata,   // intercept[19:0], solve_status[21:20], zero pad
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [CSRW-1:0] csr_wdata
);

   localparam int SW  = $clog2(NEWTON_STEPS + 1);
   localparam int ACW = 48;
   localparam int FW  = 37;
   localparam int DSM = 36;

   state_type state_ff, state_in;

   logic [16:0]              beta_ff, beta_in, b_ff, b_in;
   logic                     mode_ff, mode_in;
   logic [15:0]              alpha_ff, alpha_in;
   logic signed [15:0]       nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic signed [XW-1:0]     u_ff, u_in, v_ff, v_in;
   logic signed [5:0]        e_ff, e_in;
   logic signed [IW-1:0]     d_ff, d_in;
   logic [SW-1:0]            step_ff, step_in;
   logic [2:0]               node_ff, node_in, sh_ff, sh_in;
   logic signed [ACW-1:0]    acc_ff, acc_in, acc_full;
   logic signed [MAW-1:0]    argpre_ff, argpre_in;
   logic [ZW-1:0]            m_ff, m_in;
   logic                     neg_ff, neg_in;
   logic [TW-1:0]            t_ff, t_in;
   logic signed [FW-1:0]     fsum_ff, fsum_in, f34, tpos;
   logic [DSM-1:0]           dsum_ff, dsum_in;
   logic [25:0]              d20;
   logic [1:0]               status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [23:0]              rsp_data_ff, rsp_data_in;
   logic signed [MAW-1:0]    mul_a;
   logic signed [MBW-1:0]    mul_b;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic signed [AGW-1:0]    arg_v;
   logic signed [DVW-1:0]    qround, dnext;
   logic signed [17:0]       nsum;

   cordic_ctl_type           cor_ctl;
   logic signed [XW-1:0]     cor_x0, cor_y0, cor_x, cor_y;
   logic signed [ZW-1:0]     cor_z0, cor_z;
   logic                     cor_done;

   div_ctl_type              dv_ctl;
   logic signed [DVW-1:0]    dv_dividend, dv_quo;
   logic [DSW-1:0]           dv_divisor;
   logic                     dv_done;

   function automatic logic signed [IW-1:0] sat_intercept(input logic signed [DVW-1:0] v);
      if (v < DVW'(D_MIN)) return D_MIN;
      if (v > DVW'(D_MAX)) return D_MAX;
      return IW'(v);
   endfunction

   tiis_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .ctl    (cor_ctl),
      .x_init (cor_x0),
      .y_init (cor_y0),
      .z_init (cor_z0),
      .done   (cor_done),
      .x_out  (cor_x),
      .y_out  (cor_y),
      .z_out  (cor_z)
   );

   tiis_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctl      (dv_ctl),
      .dividend (dv_dividend),
      .divisor  (dv_divisor),
      .done     (dv_done),
      .quotient (dv_quo)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Shared terms of the datapath
   always_comb begin
      acc_full = acc_ff + ACW'(prod_ff);
      arg_v    = AGW'(prod_ff >>> 12);
      f34      = fsum_ff - $signed({3'b000, alpha_ff, 18'b0});
      d20      = dsum_ff[DSM-1:10];
      tpos     = $signed(FW'(t_ff));
      nsum     = 18'(nx_ff) + 18'(ny_ff) + 18'(nz_ff);
      qround   = (dv_quo + DVW'(8192)) >>> 14;
      dnext    = DVW'(d_ff) + dv_quo;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_ANORM_HI;
         ST_ANORM_HI:  if (u_ff < (v_ff <<< 1)) state_in = ST_ANORM_LO;
         ST_ANORM_LO:  if (!(v_ff > u_ff)) state_in = ST_ASCALE;
         ST_ASCALE:    if (u_ff >= (XW'(1) <<< 40)) state_in = ST_ACORD;
         ST_ACORD:     if (cor_done) state_in = ST_AEMUL;
         ST_AEMUL:     state_in = ST_ASUM;
         ST_ASUM:      state_in = ST_MDIV;
         ST_MDIV:      if (dv_done) state_in = mode_ff ? ST_NSTEP : ST_DONE;
         ST_NSTEP:     state_in = ST_NDOT0;
         ST_NDOT0:     state_in = ST_NDOT1;
         ST_NDOT1:     state_in = ST_NDOT2;
         ST_NDOT2:     state_in = ST_NDOT3;
         ST_NDOT3:     state_in = ST_NARGM;
         ST_NARGM:     state_in = ST_NARG;
         ST_NARG:      state_in = (arg_v < ARG_LIMIT && arg_v > -ARG_LIMIT) ?
                                  ST_NHALVE : ST_NNEXT;
         ST_NHALVE:    if (m_ff <= ZW'(ONE_Q30)) state_in = ST_NTCORD;
         ST_NTCORD:    if (cor_done) state_in = (cor_x <= 0) ? ST_NDBL : ST_NTDIV;
         ST_NTDIV:     if (dv_done) state_in = ST_NDBL;
         ST_NDBL:      state_in = (sh_ff != '0) ? ST_NDBL_DIV : ST_NACC;
         ST_NDBL_DIV:  state_in = ST_NDBL_WAIT;
         ST_NDBL_WAIT: if (dv_done) state_in = ST_NDBL;
         ST_NACC:      state_in = ST_NNEXT;
         ST_NNEXT:     state_in = (node_ff == 3'd7) ? ST_NDEN : ST_NDOT0;
         ST_NDEN:      state_in = (d20 == '0) ? ST_DONE : ST_NDEN_DIV;
         ST_NDEN_DIV:  state_in = ST_NDDIV;
         ST_NDDIV: begin
            if (dv_done) begin
               if (dv_quo == '0 || step_ff == SW'(NEWTON_STEPS - 1)) state_in = ST_DONE;
               else state_in = ST_NSTEP;
            end
         end
         ST_DONE:      if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Unit controls and multiplier operands
   always_comb begin
      cor_ctl     = '0;
      cor_x0      = u_ff;
      cor_y0      = v_ff;
      cor_z0      = '0;
      dv_ctl      = '0;
      dv_dividend = '0;
      dv_divisor  = DSW'(b_ff);
      mul_a       = '0;
      mul_b       = '0;
      case (state_ff)
         ST_ASCALE: begin
            cor_ctl.start     = (u_ff >= (XW'(1) <<< 40));
            cor_ctl.vectoring = 1'b1;
         end
         ST_AEMUL: begin
            mul_a = MAW'(e_ff);
            mul_b = MBW'({1'b0, HALF_LN2});
         end
         ST_ASUM: begin
            dv_ctl.start = 1'b1;
            dv_ctl.qbits = QBITS_FULL;
            dv_dividend  = (DVW'(cor_z) + DVW'(prod_ff)) <<< 12;
         end
         ST_NDOT0: begin
            mul_a = MAW'(nx_ff);
            mul_b = MBW'({1'b0, node_ff[2] ? GAUSS_HI : GAUSS_LO});
         end
         ST_NDOT1: begin
            mul_a = MAW'(ny_ff);
            mul_b = MBW'({1'b0, node_ff[1] ? GAUSS_HI : GAUSS_LO});
         end
         ST_NDOT2: begin
            mul_a = MAW'(nz_ff);
            mul_b = MBW'({1'b0, node_ff[0] ? GAUSS_HI : GAUSS_LO});
         end
         ST_NARGM: begin
            mul_a = argpre_ff;
            mul_b = MBW'({1'b0, b_ff});
         end
         ST_NHALVE: begin
            cor_ctl.start = (m_ff <= ZW'(ONE_Q30));
            cor_x0        = XW'({1'b0, ONE_Q30});
            cor_y0        = '0;
            cor_z0        = $signed(m_ff);
         end
         ST_NTCORD: begin
            dv_ctl.start = cor_done && (cor_x > 0);
            dv_ctl.qbits = QBITS_TANH;
            dv_dividend  = DVW'(cor_y) <<< FRAC;
            dv_divisor   = DSW'(cor_x);
         end
         ST_NDBL: begin
            mul_a = MAW'({1'b0, t_ff});
            mul_b = MBW'({1'b0, t_ff});
         end
         ST_NDBL_DIV: begin
            dv_ctl.start = 1'b1;
            dv_ctl.qbits = QBITS_TANH;
            dv_dividend  = $signed(DVW'(t_ff)) <<< (FRAC + 1);
            dv_divisor   = DSW'(ONE_Q30) + DSW'(prod_ff >>> FRAC);
         end
         ST_NDEN: begin
            mul_a = MAW'({1'b0, d20});
            mul_b = MBW'({1'b0, b_ff});
         end
         ST_NDEN_DIV: begin
            dv_ctl.start = 1'b1;
            dv_ctl.qbits = QBITS_FULL;
            dv_dividend  = -(DVW'(f34) <<< 18);
            dv_divisor   = DSW'(prod_ff);
         end
         default: ;
      endcase
      prod_in = PW'(mul_a) * PW'(mul_b);
   end

   // Datapath register updates
   always_comb begin
      beta_in      = beta_ff;
      mode_in      = mode_ff;
      b_in         = b_ff;
      alpha_in     = alpha_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      nz_in        = nz_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      e_in         = e_ff;
      d_in         = d_ff;
      step_in      = step_ff;
      node_in      = node_ff;
      sh_in        = sh_ff;
      acc_in       = acc_ff;
      argpre_in    = argpre_ff;
      m_in         = m_ff;
      neg_in       = neg_ff;
      t_in         = t_ff;
      fsum_in      = fsum_ff;
      dsum_in      = dsum_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the result once taken
      if (rsp_tready) rsp_valid_in = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_BETA: beta_in = csr_wdata;
            CSR_MODE: mode_in = csr_wdata[0];
            default:  ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               alpha_in = req_tdata[15:0];
               nx_in    = req_tdata[31:16];
               ny_in    = req_tdata[47:32];
               nz_in    = req_tdata[63:48];
               b_in     = (beta_ff == '0) ? 17'd1 : beta_ff;
               u_in     = (req_tdata[15:0] == '0) ? XW'(1) : XW'(req_tdata[15:0]);
               v_in     = XW'(65536) - ((req_tdata[15:0] == '0) ? XW'(1) :
                                        XW'(req_tdata[15:0]));
               e_in     = '0;
               status_in = STAT_MIDPOINT;
            end
         end
         ST_ANORM_HI: begin
            if (u_ff >= (v_ff <<< 1)) begin
               v_in = v_ff <<< 1;
               e_in = e_ff + 6'sd1;
            end
         end
         ST_ANORM_LO: begin
            if (v_ff > u_ff) begin
               u_in = u_ff <<< 1;
               e_in = e_ff - 6'sd1;
            end else begin
               u_in = u_ff + v_ff;
               v_in = u_ff - v_ff;
            end
         end
         ST_ASCALE: begin
            if (u_ff < (XW'(1) <<< 40)) begin
               u_in = u_ff <<< 1;
               v_in = v_ff <<< 1;
            end
         end
         ST_MDIV: begin
            if (dv_done) begin
               d_in    = sat_intercept(qround - (DVW'(nsum) <<< 1));
               step_in = '0;
            end
         end
         ST_NSTEP: begin
            fsum_in = '0;
            dsum_in = '0;
            node_in = '0;
         end
         ST_NDOT1: acc_in = ACW'(prod_ff);
         ST_NDOT2: acc_in = acc_full;
         ST_NDOT3: argpre_in = MAW'(acc_full >>> 14) + (MAW'(d_ff) <<< 14);
         ST_NARG: begin
            neg_in = arg_v[AGW-1];
            m_in   = ZW'(arg_v[AGW-1] ? -arg_v : arg_v);
            sh_in  = '0;
            // saturated node: full weight when positive, none when negative
            if (!(arg_v < ARG_LIMIT && arg_v > -ARG_LIMIT) && !arg_v[AGW-1])
               fsum_in = fsum_ff + (FW'(ONE_Q30) <<< 1);
         end
         ST_NHALVE: begin
            if (m_ff > ZW'(ONE_Q30)) begin
               m_in  = m_ff >> 1;
               sh_in = sh_ff + 3'd1;
            end
         end
         ST_NTCORD: begin
            if (cor_done && cor_x <= 0) t_in = ONE_Q30;
         end
         ST_NTDIV: begin
            if (dv_done) begin
               if (dv_quo < 0) t_in = '0;
               else if (dv_quo > DVW'(ONE_Q30)) t_in = ONE_Q30;
               else t_in = TW'(dv_quo);
            end
         end
         ST_NDBL_WAIT: begin
            if (dv_done) begin
               t_in  = TW'(dv_quo);
               sh_in = sh_ff - 3'd1;
            end
         end
         ST_NACC: begin
            fsum_in = fsum_ff + FW'(ONE_Q30) + (neg_ff ? -tpos : tpos);
            dsum_in = dsum_ff + DSM'(ONE_Q30) - DSM'(prod_ff >>> FRAC);
         end
         ST_NNEXT: node_in = node_ff + 3'd1;
         ST_NDEN: if (d20 == '0) status_in = STAT_FLAT;
         ST_NDDIV: begin
            if (dv_done) begin
               if (dv_quo == '0) begin
                  status_in = STAT_CONVERGED;
               end else begin
                  d_in    = sat_intercept(dnext);
                  step_in = step_ff + SW'(1);
                  if (step_ff == SW'(NEWTON_STEPS - 1)) status_in = STAT_LIMIT;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, status_ff, d_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         beta_ff      <= BETA_RESET;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         beta_ff      <= beta_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      b_ff        <= b_in;
      alpha_ff    <= alpha_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      nz_ff       <= nz_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      e_ff        <= e_in;
      d_ff        <= d_in;
      step_ff     <= step_in;
      node_ff     <= node_in;
      sh_ff       <= sh_in;
      acc_ff      <= acc_in;
      argpre_ff   <= argpre_in;
      m_ff        <= m_in;
      neg_ff      <= neg_in;
      t_ff        <= t_in;
      fsum_ff     <= fsum_in;
      dsum_ff     <= dsum_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= prod_in;
   end

   // Sequencer checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in flight");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final state");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      dv_done |-> (state_ff == ST_MDIV || state_ff == ST_NTDIV ||
                   state_ff == ST_NDBL_WAIT || state_ff == ST_NDDIV))
      else $error("divider finished while the sequencer was not waiting");

   a_cordic_done_expected: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == ST_ACORD || state_ff == ST_NTCORD))
      else $error("CORDIC finished while the sequencer was not waiting");

endmodule

`default_nettype wire

// ===== design/tiis_cordic.sv =====
// Hyperbolic CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on tiis_pkg for the angle table and control struct.
`default_nettype none

module tiis_cordic import tiis_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cordic_ctl_type        ctl,
   input  logic signed [XW-1:0]  x_init,
   input  logic signed [XW-1:0]  y_init,
   input  logic signed [ZW-1:0]  z_init,
   output logic                  done,
   output logic signed [XW-1:0]  x_out,
   output logic signed [XW-1:0]  y_out,
   output logic signed [ZW-1:0]  z_out
);

   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ZW-1:0] z_ff, z_in, ang;
   logic [4:0]           idx_ff, idx_in;
   logic                 rep_ff, rep_in, busy_ff, busy_in, vec_ff, vec_in, done_ff, done_in;
   logic                 down;

   // One micro-rotation; indexes 4 and 13 run twice
   always_comb begin
      xs     = x_ff >>> idx_ff;
      ys     = y_ff >>> idx_ff;
      ang    = ZW'(HYP_TAB[idx_ff]);
      down   = vec_ff ? (y_ff >= 0) : (z_ff < 0);
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      idx_in = idx_ff;
      rep_in = rep_ff;
      busy_in = busy_ff;
      vec_in = vec_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         x_in    = x_init;
         y_in    = y_init;
         z_in    = z_init;
         idx_in  = 5'd1;
         rep_in  = 1'b0;
         busy_in = 1'b1;
         vec_in  = ctl.vectoring;
      end else if (busy_ff) begin
         if (down) begin
            x_in = x_ff - ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang;
         end
         if ((idx_ff == 5'd4 || idx_ff == 5'd13) && !rep_ff) begin
            rep_in = 1'b1;
         end else begin
            rep_in = 1'b0;
            if (idx_ff == 5'(FRAC)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               idx_in = idx_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      idx_ff <= idx_in;
      rep_ff <= rep_in;
      vec_ff <= vec_in;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

`default_nettype wire

// ===== design/tiis_divider.sv =====
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on tiis_pkg for widths and the control struct.
`default_nettype none

module tiis_divider import tiis_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  div_ctl_type            ctl,
   input  logic signed [DVW-1:0]  dividend,
   input  logic [DSW-1:0]         divisor,
   output logic                   done,
   output logic signed [DVW-1:0]  quotient
);

   logic [DVW-1:0]        mag, dq_ff, dq_in;
   logic [DSW-1:0]        rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DSW:0]          trial;
   logic [QBW-1:0]        cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in, ge;
   logic signed [DVW-1:0] quo_ff, quo_in;

   // Load magnitudes, then shift one dividend bit into the remainder per cycle
   always_comb begin
      mag     = dividend[DVW-1] ? DVW'(-dividend) : DVW'(dividend);
      trial   = {rem_ff, dq_ff[DVW-1]};
      ge      = trial >= {1'b0, dsr_ff};
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rem_in  = DSW'(mag >> ctl.qbits);
         dq_in   = mag << (QBW'(DVW) - ctl.qbits);
         dsr_in  = divisor;
         cnt_in  = ctl.qbits;
         neg_in  = dividend[DVW-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = ge ? DSW'(trial - {1'b0, dsr_ff}) : DSW'(trial);
            dq_in  = {dq_ff[DVW-2:0], ge};
            cnt_in = cnt_ff - QBW'(1);
         end else begin
            quo_in  = neg_ff ? -$signed(dq_ff) : $signed(dq_ff);
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the THINC intercept solver: directed table, then random items.
// Depends on tiis_pkg and the thinc_interface_intercept_solver RTL with its tiis_cordic and tiis_divider units.
// A bit-exact fixed-point predictor computes each expected intercept and status.
`default_nettype none

module tb_top import tiis_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Q30     = 64'sd1 << 30;
   localparam longint ARG_SAT = 64'sd20 << 30;
   localparam int     N_RAND  = 400;

   typedef struct {
      logic signed [19:0] d;
      logic [1:0]         st;
   } icpt_t;

   typedef struct {
      int          beta;
      int          mode;
      int          alpha;
      int          nx, ny, nz;
      bit          typed;
      int          exp_d;
      logic [1:0]  exp_st;
   } dir_row_t;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [63:0]     req_tdata = '0;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [23:0]     rsp_tdata;
   logic            csr_we = 1'b0;
   logic            csr_index = CSR_BETA;
   logic [CSRW-1:0] csr_wdata = '0;

   thinc_interface_intercept_solver dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor copy of the registers and the angle tables
   longint      atab [1:30];
   longint      half_ln2_q30;
   int unsigned cur_beta = 24576;
   int unsigned cur_mode = 0;

   icpt_t intercept_q [$];
   int    n_fail = 0;
   int    n_items = 0;
   int    n_gauss = 0;
   int    n_results = 0;
   int    st_count [4] = '{0, 0, 0, 0};
   bit    quiet = 1'b0;
   bit    hold_req = 1'b0;

   // hyperbolic angle table and ln(2)/2, from their odd power series
   function automatic void build_angles();
      longint unsigned s, p;
      for (int i = 1; i <= 30; i++) begin
         s = 0;
         for (int k = 1; i * k <= 60; k += 2)
            s += (64'd1 << (60 - i * k)) / longint'(k);
         atab[i] = longint'((s + (64'd1 << 29)) >> 30);
      end
      s = 0;
      p = (64'd1 << 60) / 3;
      for (int k = 1; p != 0; k += 2) begin
         s += p / longint'(k);
         p = p / 9;
      end
      half_ln2_q30 = longint'((s + (64'd1 << 29)) >> 30);
   endfunction

   // CORDIC rotation: tanh of z in [0, 1], Q30
   function automatic longint tanh_unit(longint z);
      longint x, y, xs, ys, t;
      x = Q30;
      y = 0;
      for (int i = 1; i <= 30; i++) begin
         for (int r = 0; r < ((i == 4 || i == 13) ? 2 : 1); r++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin x += ys; y += xs; z -= atab[i]; end
            else begin x -= ys; y -= xs; z += atab[i]; end
         end
      end
      if (x <= 0) return Q30;
      t = (y * Q30) / x;
      return t < 0 ? 64'sd0 : (t > Q30 ? Q30 : t);
   endfunction

   // tanh for any argument: halve into range, then apply the doubling formula
   function automatic longint tanh_any(longint a);
      longint m, t;
      int sh;
      m = a < 0 ? -a : a;
      sh = 0;
      while (m > Q30) begin m = m >>> 1; sh++; end
      t = tanh_unit(m);
      for (; sh > 0; sh--)
         t = (2 * t * Q30) / (Q30 + (t * t) / Q30);
      return a < 0 ? -t : t;
   endfunction

   // atanh(2a - 1) in Q30 by CORDIC vectoring after power-of-two normalization
   function automatic longint atanh_frac(int unsigned a);
      longint u, v, x, y, z, xs, ys, e;
      if (a == 0) a = 1;
      u = longint'(a);
      v = 65536 - longint'(a);
      e = 0;
      z = 0;
      while (u >= 2 * v) begin v *= 2; e++; end
      while (v > u) begin u *= 2; e--; end
      x = u + v;
      y = u - v;
      while (x < (64'sd1 << 40)) begin x *= 2; y *= 2; end
      for (int i = 1; i <= 30; i++) begin
         for (int r = 0; r < ((i == 4 || i == 13) ? 2 : 1); r++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin x -= ys; y -= xs; z += atab[i]; end
            else begin x += ys; y += xs; z -= atab[i]; end
         end
      end
      return z + e * half_ln2_q30;
   endfunction

   function automatic longint clamp_d(longint v);
      return v < -524288 ? -64'sd524288 : (v > 524287 ? 64'sd524287 : v);
   endfunction

   // expected intercept and status for one item under the current registers
   function automatic icpt_t solve_intercept(logic [63:0] item);
      icpt_t  res;
      longint n [3];
      longint g [2];
      longint a, b, d, dot, arg, th, fsum, dsum, f34, d20, dd;
      a = longint'(item[15:0]);
      n[0] = longint'($signed(item[31:16]));
      n[1] = longint'($signed(item[47:32]));
      n[2] = longint'($signed(item[63:48]));
      b = cur_beta != 0 ? longint'(cur_beta) : 64'sd1;
      g[0] = 64'sd226908346;
      g[1] = Q30 - g[0];
      d = (atanh_frac(int'(a)) * 4096 / b + 8192) >>> 14;
      d = clamp_d(d - 2 * (n[0] + n[1] + n[2]));
      res.st = STAT_MIDPOINT;
      if (cur_mode != 0) begin
         res.st = STAT_LIMIT;
         for (int step = 0; step < 8; step++) begin
            fsum = 0;
            dsum = 0;
            for (int c = 0; c < 8; c++) begin
               dot = (n[0] * g[(c >> 2) & 1] + n[1] * g[(c >> 1) & 1] + n[2] * g[c & 1]) >>> 14;
               arg = ((dot + d * 16384) * b) >>> 12;
               if (arg < ARG_SAT && arg > -ARG_SAT) begin
                  th = tanh_any(arg);
                  fsum += Q30 + th;
                  dsum += Q30 - (th * th) / Q30;
               end else if (arg > 0) begin
                  fsum += 2 * Q30;
               end
            end
            f34 = fsum - a * 262144;
            d20 = dsum >>> 10;
            if (d20 <= 0) begin res.st = STAT_FLAT; break; end
            dd = -(f34 * 262144) / (b * d20);
            if (dd == 0) begin res.st = STAT_CONVERGED; break; end
            d = clamp_d(d + dd);
         end
      end
      res.d = d[19:0];
      return res;
   endfunction

   // clock and reset
   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // write both registers once every expected item has come back
   task automatic set_regs(int unsigned beta_v, int unsigned mode_v);
      // withdraw the last item so it is not taken a second time
      req_tvalid <= 1'b0;
      while (intercept_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_BETA;
      csr_wdata <= CSRW'(beta_v);
      @(negedge clock);
      csr_index <= CSR_MODE;
      csr_wdata <= CSRW'(mode_v);
      @(negedge clock);
      csr_we <= 1'b0;
      cur_beta = beta_v;
      cur_mode = mode_v;
   endtask

   // offer one item, hold it until accepted, record its expectation
   task automatic send_item(logic [63:0] item, bit typed, icpt_t typed_res);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= item;
      do @(posedge clock); while (!req_tready);
      intercept_q.push_back(typed ? typed_res : solve_intercept(item));
      n_items++;
      if (cur_mode != 0) n_gauss++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_normal();
      case ($urandom_range(0, 9))
         7: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         8, 9: return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic [15:0] rand_alpha();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 64));
         default: return 16'($urandom);
      endcase
   endfunction

   // directed rows: extremes, both modes, zero beta, saturation, off-unit normals
   dir_row_t dir_tab [15] = '{
      '{24576, 0, 32768, 0, 0, 0, 0, 0, STAT_MIDPOINT},
      '{24576, 0, 0, 0, 0, 0, 0, 0, STAT_MIDPOINT},
      '{0, 0, 65535, -16384, -16384, -16384, 1, 524287, STAT_MIDPOINT},
      '{0, 0, 0, 16384, 16384, 16384, 1, -524288, STAT_MIDPOINT},
      '{131071, 0, 65535, 16384, 0, 0, 0, 0, STAT_MIDPOINT},
      '{4096, 0, 1, 0, 16384, 0, 0, 0, STAT_MIDPOINT},
      '{24576, 1, 32768, 16384, 0, 0, 0, 0, STAT_MIDPOINT},
      '{24576, 1, 0, 0, 0, 16384, 0, 0, STAT_MIDPOINT},
      '{24576, 1, 65535, -16384, 0, 0, 0, 0, STAT_MIDPOINT},
      '{131071, 1, 16384, 11585, 11585, 0, 0, 0, STAT_MIDPOINT},
      '{4096, 1, 49152, 9459, 9459, 9459, 0, 0, STAT_MIDPOINT},
      '{24576, 1, 40000, 32767, -32768, 0, 0, 0, STAT_MIDPOINT},
      '{0, 1, 30000, 0, 0, 0, 0, 0, STAT_MIDPOINT},
      '{131071, 1, 65535, 16384, 16384, 16384, 0, 0, STAT_MIDPOINT},
      '{24576, 1, 20000, 0, -16384, 0, 0, 0, STAT_MIDPOINT}
   };

   // sender: directed table, then random phases of register settings
   initial begin
      icpt_t       typed_res;
      logic [63:0] item;
      int unsigned beta_v;
      build_angles();
      @(negedge reset);
      @(negedge clock);
      foreach (dir_tab[i]) begin
         if (i == 0 || dir_tab[i].beta != cur_beta || dir_tab[i].mode != cur_mode)
            set_regs(dir_tab[i].beta, dir_tab[i].mode);
         item = {16'(dir_tab[i].nz), 16'(dir_tab[i].ny), 16'(dir_tab[i].nx),
                 16'(dir_tab[i].alpha)};
         typed_res.d = 20'(dir_tab[i].exp_d);
         typed_res.st = dir_tab[i].exp_st;
         send_item(item, dir_tab[i].typed, typed_res);
      end
      for (int i = 0; i < N_RAND; i++) begin
         if (i % 50 == 0) begin
            case ($urandom_range(0, 5))
               0: beta_v = 4096;
               1: beta_v = 131071;
               2: beta_v = 0;
               default: beta_v = $urandom_range(4096, 131071);
            endcase
            set_regs(beta_v, (i / 50) % 2);
         end
         // long receiver hold while items keep coming
         if (i == 110) hold_req = 1'b1;
         if (i >= N_RAND - 40) quiet = 1'b1;
         send_item({rand_normal(), rand_normal(), rand_normal(), rand_alpha()}, 1'b0,
                   typed_res);
      end
      req_tvalid <= 1'b0;
      while (intercept_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("Covered %0d items (%0d in Gauss mode): status counts %0d/%0d/%0d/%0d.",
               n_items, n_gauss, st_count[0], st_count[1], st_count[2], st_count[3]);
      $display("Register settings spanned beta 0, 4096, 131071 and random; %0d mismatches.",
               n_fail);
      if (n_fail == 0)
         $display("PASS thinc_interface_intercept_solver");
      else
         $display("FAIL thinc_interface_intercept_solver");
      $finish;
   end

   // receiver: random stall bursts, one long hold, none near the end
   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (600) @(negedge clock);
            hold_req = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each accepted item with the oldest expectation
   always @(posedge clock) begin
      icpt_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         st_count[rsp_tdata[21:20]]++;
         if (intercept_q.size() == 0) begin
            n_fail++;
            if (n_fail <= 10)
               $display("ERROR: unexpected item d=%0d status=%0d",
                        $signed(rsp_tdata[19:0]), rsp_tdata[21:20]);
         end else begin
            want = intercept_q.pop_front();
            if (rsp_tdata[19:0] !== want.d || rsp_tdata[21:20] !== want.st) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("ERROR: item %0d d exp %0d got %0d, status exp %0d got %0d",
                           n_results, want.d, $signed(rsp_tdata[19:0]), want.st,
                           rsp_tdata[21:20]);
            end
         end
      end
   end

   // timeout: far beyond the slowest run of all items at the Gauss worst case
   initial begin
      #(64'd720_000_000);
      $display("FAIL thinc_interface_intercept_solver");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
design/tiis_pkg.sv
design/tiis_cordic.sv
design/tiis_divider.sv
design/thinc_interface_intercept_solver.sv
sim/tb_top.sv
